// ----- hw/rtl/streaming_substring_line_matcher_top_defines.svh -----
// Assertion macros shared by the line matcher RTL.
// No dependencies; each macro expects i_clk and i_rst_n in the enclosing scope.
`ifndef STREAMING_SUBSTRING_LINE_MATCHER_TOP_DEFINES_SVH
`define STREAMING_SUBSTRING_LINE_MATCHER_TOP_DEFINES_SVH

// Property that must hold on every clock edge outside reset
`define SLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define SLM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/slm_pkg.sv -----
// Package for the streaming line matcher: field widths, byte codes,
// register indexes and the result struct. No dependencies.
`timescale 1ns / 1ps

package slm_pkg;

    // Fixed field widths
    localparam int PAT_BYTES   = 16;
    localparam int PAT_LEN_W   = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LINE_W      = 32;
    localparam int COL_OUT_W   = 16;
    localparam int CNT_OUT_W   = 32;
    localparam int OUT_DATA_W  = LINE_W + COL_OUT_W + 2 * CNT_OUT_W;

    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // Byte codes
    localparam logic [7:0] BYTE_NL     = 8'h0A;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] BYTE_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

    // One result item
    typedef struct packed {
        logic                 match_found;
        logic [LINE_W-1:0]    match_line;
        logic [COL_OUT_W-1:0] match_column;
        logic [CNT_OUT_W-1:0] printable_count;
        logic [CNT_OUT_W-1:0] other_count;
    } t_result;

    // Control, space and DEL bytes go to the "other" count
    function automatic logic is_other(input logic [7:0] b);
        return (b < CTRL_LIMIT) || (b == BYTE_DEL) || (b == BYTE_SPACE);
    endfunction

endpackage

// ----- hw/rtl/slm_cfg.sv -----
// Configuration registers and the pattern aligned to the byte window.
// Depends on slm_pkg.
`timescale 1ns / 1ps

module slm_cfg #(
    parameter int MAX_PATTERN = 16,
    parameter int LEN_W       = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [slm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [LEN_W-1:0]               o_len,
    output logic [MAX_PATTERN*8-1:0]       o_pat_aligned,
    output logic [MAX_PATTERN-1:0]         o_pat_mask
);
    import slm_pkg::*;

    localparam int CMP_W = (LEN_W > PAT_LEN_W) ? LEN_W + 1 : PAT_LEN_W + 1;

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [PAT_LEN_W-1:0]  r_len;
    logic [7:0]            w_pat [PAT_BYTES];
    logic [CMP_W-1:0]      w_len_wide;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= PAT_LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PAT_LO:  r_pat_lo <= i_cfg_data;
                REG_PAT_HI:  r_pat_hi <= i_cfg_data;
                REG_PAT_LEN: r_len    <= i_cfg_data[PAT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pattern as bytes, byte 0 lowest
    always_comb begin
        for (int k = 0; k < PAT_BYTES / 2; k++) begin
            w_pat[k]                 = r_pat_lo[k*8 +: 8];
            w_pat[k + PAT_BYTES / 2] = r_pat_hi[k*8 +: 8];
        end
    end

    // Effective length, clamped to the window depth
    assign w_len_wide = CMP_W'(r_len);
    assign o_len = (w_len_wide > CMP_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                       : LEN_W'(r_len);

    // Window slot j (0 = newest byte) must equal pattern byte len-1-j
    always_comb begin
        int idx;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            idx = int'(o_len) - 1 - j;
            o_pat_mask[j] = (j < int'(o_len));
            if (idx >= 0 && idx < PAT_BYTES) begin
                o_pat_aligned[j*8 +: 8] = w_pat[idx[3:0]];
            end else begin
                o_pat_aligned[j*8 +: 8] = BYTE_NUL;
            end
        end
    end

endmodule

// ----- hw/rtl/slm_window.sv -----
// Shift line of recent text bytes and the parallel compare with the pattern.
// Depends on slm_pkg.
`timescale 1ns / 1ps

module slm_window #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                     i_clk,
    input  logic                     i_fire,
    input  logic [7:0]               i_byte,
    input  logic [MAX_PATTERN*8-1:0] i_pat_aligned,
    input  logic [MAX_PATTERN-1:0]   i_pat_mask,
    output logic                     o_eq
);
    import slm_pkg::*;

    logic [7:0] w_win [MAX_PATTERN];

    // Slot 0 is the byte being processed
    assign w_win[0] = i_byte;

    // Older bytes, shifted once per processed item
    if (MAX_PATTERN > 1) begin : g_hist
        logic [7:0] r_hist [MAX_PATTERN-1];

        always_ff @(posedge i_clk) begin
            if (i_fire) begin
                r_hist[0] <= i_byte;
                for (int k = 1; k < MAX_PATTERN - 1; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
            end
        end

        for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_tap
            assign w_win[j] = r_hist[j-1];
        end
    end

    // All used slots must agree
    always_comb begin
        o_eq = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (i_pat_mask[j] && (i_pat_aligned[j*8 +: 8] != w_win[j])) begin
                o_eq = 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/slm_track.sv -----
// Line, column and byte-count tracking plus the match decision.
// Depends on slm_pkg and the assertion macro header.
`timescale 1ns / 1ps

module slm_track #(
    parameter int COLUMN_BITS = 16,
    parameter int COUNT_BITS  = 32,
    parameter int LEN_W       = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_win_eq,
    output slm_pkg::t_result o_res
);
    import slm_pkg::*;

    logic [LINE_W-1:0]      r_line;
    logic [COLUMN_BITS-1:0] r_col;
    logic [COLUMN_BITS-1:0] r_next;
    logic                   r_zero;
    logic [COUNT_BITS-1:0]  r_prn;
    logic [COUNT_BITS-1:0]  r_oth;

    logic [COUNT_BITS-1:0]  n_prn;
    logic [COUNT_BITS-1:0]  n_oth;
    logic                   w_other;
    logic                   w_col_ok;
    logic [COLUMN_BITS-1:0] w_col_new;
    logic [COLUMN_BITS-1:0] w_len;
    logic [COLUMN_BITS-1:0] w_start;
    logic [COLUMN_BITS:0]   w_start_p1;
    logic [COLUMN_BITS+COL_OUT_W:0]     w_start_ext;
    logic [COUNT_BITS+CNT_OUT_W-1:0]    w_prn_ext;
    logic [COUNT_BITS+CNT_OUT_W-1:0]    w_oth_ext;
    logic                   w_zero;
    logic                   w_nl;
    logic                   w_hit;
    logic                   w_line_clr;

    // Byte class counts, saturating
    assign w_other = is_other(i_byte);
    assign n_prn = (!w_other && (r_prn != '1)) ? r_prn + 1'b1 : r_prn;
    assign n_oth = ( w_other && (r_oth != '1)) ? r_oth + 1'b1 : r_oth;

    // Column after this byte; a saturated column blocks matches
    assign w_col_ok  = (r_col != '1);
    assign w_col_new = w_col_ok ? r_col + 1'b1 : r_col;
    assign w_len     = COLUMN_BITS'(i_len);
    assign w_start   = w_col_new - w_len;
    assign w_zero    = r_zero || (i_byte == BYTE_NUL);
    assign w_nl      = (i_byte == BYTE_NL);

    // Match ends here: window equal, inside the line, after the last match
    assign w_hit = w_col_ok && !w_zero && (i_len != '0) && (w_col_new >= w_len)
                   && (w_start >= r_next) && i_win_eq;

    // Field formatting
    assign w_start_p1  = {1'b0, w_start} + 1'b1;
    assign w_start_ext = {{COL_OUT_W{1'b0}}, w_start_p1};
    assign w_prn_ext   = {{CNT_OUT_W{1'b0}}, n_prn};
    assign w_oth_ext   = {{CNT_OUT_W{1'b0}}, n_oth};

    always_comb begin
        o_res.match_found     = w_hit;
        o_res.match_line      = r_line;
        o_res.match_column    = w_hit ? w_start_ext[COL_OUT_W-1:0] : '0;
        o_res.printable_count = w_prn_ext[CNT_OUT_W-1:0];
        o_res.other_count     = w_oth_ext[CNT_OUT_W-1:0];
    end

    // State update once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= LINE_W'(1);
            r_col  <= '0;
            r_next <= '0;
            r_zero <= 1'b0;
            r_prn  <= '0;
            r_oth  <= '0;
        end else if (i_fire) begin
            r_prn <= n_prn;
            r_oth <= n_oth;
            if (w_nl) begin
                if (r_line != LINE_MAX) begin
                    r_line <= r_line + 1'b1;
                end
                r_col  <= '0;
                r_next <= '0;
                r_zero <= 1'b0;
            end else begin
                r_col  <= w_col_new;
                r_zero <= w_zero;
                if (w_hit) begin
                    r_next <= w_col_new;
                end
            end
        end
    end

    // Line state as it must look right after a newline
    assign w_line_clr = (r_col == '0) && !r_zero && (r_next == '0);

    `include "streaming_substring_line_matcher_top_defines.svh"

    `SLM_ASSERT(a_line_nonzero, r_line != '0, "line number reached zero")
    `SLM_ASSERT(a_next_le_col, r_next <= r_col, "next match start beyond column")
    `SLM_ASSERT_NEXT(a_nl_clears, i_fire && w_nl, w_line_clr, "newline left line state")

endmodule

// ----- hw/rtl/streaming_substring_line_matcher_top.sv -----
// Top level of the streaming fixed-pattern line matcher.
// Depends on slm_pkg, slm_cfg, slm_window, slm_track and the macro header.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+----------------------------------
//  s_axis    | in        | tvalid / tready      | tdata[7:0] text_byte
//  m_axis    | out       | tvalid / tready      | tuser[0] match_found, tdata fields
//  cfg       | in        | valid / ready        | index[1:0], data[63:0]
//
// One text byte per cycle sustained while m_axis takes results; each byte passes
// the input register, then the result register, before its result is valid.
// The compare and the counter updates sit between those two registers.
// Reset (i_rst_n low, synchronous) restores pattern length 1, line 1 and zero
// counts; no clearing pass is needed.
// When m_axis stalls, the result is held and the input register fills; s_axis
// tready drops only while both are full.
`timescale 1ns / 1ps

module streaming_substring_line_matcher_top #(
    parameter int MAX_PATTERN = 16,
    parameter int COLUMN_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Text input
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] text_byte
    // Results
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] match_line, [47:32] match_column,
    // [79:48] printable_count, [111:80] other_count
    output logic [slm_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [0:0]                     o_m_axis_tuser,  // [0] match_found
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [slm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    logic                     r_out_valid;
    t_result                  r_out_res;
    logic                     w_out_free;
    logic                     w_fire;
    logic [LEN_W-1:0]         w_len;
    logic [MAX_PATTERN*8-1:0] w_pat_aligned;
    logic [MAX_PATTERN-1:0]   w_pat_mask;
    logic                     w_win_eq;
    t_result                  w_res;
    logic                     w_in_stall;
    logic                     w_out_miss;

    // Handshake
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;
    assign o_cfg_ready     = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    slm_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_len         (w_len),
        .o_pat_aligned (w_pat_aligned),
        .o_pat_mask    (w_pat_mask)
    );

    slm_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk         (i_clk),
        .i_fire        (w_fire),
        .i_byte        (r_in_byte),
        .i_pat_aligned (w_pat_aligned),
        .i_pat_mask    (w_pat_mask),
        .o_eq          (w_win_eq)
    );

    slm_track #(
        .COLUMN_BITS (COLUMN_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .LEN_W       (LEN_W)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .i_len    (w_len),
        .i_win_eq (w_win_eq),
        .o_res    (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tuser[0] = r_out_res.match_found;
    assign o_m_axis_tdata    = {r_out_res.other_count, r_out_res.printable_count,
                                r_out_res.match_column, r_out_res.match_line};

    // Conditions watched by the checks below
    assign w_in_stall = r_in_valid && !w_out_free;
    assign w_out_miss = r_out_valid && !r_out_res.match_found;

    `include "streaming_substring_line_matcher_top_defines.svh"

    `SLM_ASSERT_NEXT(a_fire_gives_result, w_fire, r_out_valid, "processed item left no result")
    `SLM_ASSERT_NEXT(a_in_hold, w_in_stall, r_in_valid && $stable(r_in_byte), "input not held")
    `SLM_ASSERT_IMPL(a_col_zero, w_out_miss, r_out_res.match_column == '0, "stray column")

endmodule

// ----- tb/line_match_checker.sv -----
// Checker for the streaming line matcher: watches the config, text and result channels,
// predicts each result from its own copy of the matcher state and compares field by field.
// Depends on slm_pkg for widths, byte codes, register indexes and the result struct.
`timescale 1ns / 1ps

module line_match_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [slm_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [0:0]                     i_m_tuser,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [slm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import slm_pkg::*;

    localparam int                   MAX_PAT     = PAT_BYTES;
    localparam logic [COL_OUT_W-1:0] COL_LIMIT   = '1;
    localparam logic [CNT_OUT_W-1:0] CNT_LIMIT   = '1;

    // Pattern registers as the block should hold them
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [PAT_LEN_W-1:0]  pat_len;

    // Line tracking state
    logic [7:0]           recent [MAX_PAT];
    logic [LINE_W-1:0]    line_no;
    logic [COL_OUT_W-1:0] col;
    logic [COL_OUT_W-1:0] next_start;
    logic                 zero_seen;
    logic [CNT_OUT_W-1:0] printable_total;
    logic [CNT_OUT_W-1:0] other_total;

    // Results still owed by the block, oldest first
    t_result pending_results [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 'h%0h, want 'h%0h",
                 $time, what, got, want);
        o_errors++;
    endtask

    task automatic clear_matcher();
        pat_lo          = '0;
        pat_hi          = '0;
        pat_len         = 5'd1;
        for (int i = 0; i < MAX_PAT; i++)
            recent[i] = 8'h00;
        line_no         = 32'd1;
        col             = '0;
        next_start      = '0;
        zero_seen       = 1'b0;
        printable_total = '0;
        other_total     = '0;
        pending_results.delete();
    endtask

    // Advance the matcher state by one text byte and return the result it causes
    task automatic predict_line_result(input logic [7:0] b, output t_result r);
        int                   eff_len;
        logic                 hit;
        logic                 col_ok;
        logic [COL_OUT_W-1:0] start;
        logic [127:0]         pat;

        pat     = {pat_hi, pat_lo};
        eff_len = (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);

        // Control bytes, DEL and space go to the other count
        if (b < CTRL_LIMIT || b == BYTE_DEL || b == BYTE_SPACE) begin
            if (other_total != CNT_LIMIT)
                other_total++;
        end else if (printable_total != CNT_LIMIT) begin
            printable_total++;
        end

        for (int i = MAX_PAT - 1; i > 0; i--)
            recent[i] = recent[i-1];
        recent[0] = b;

        // A byte that finds the column saturated cannot end a match
        col_ok = (col != COL_LIMIT);
        if (col_ok)
            col++;
        if (b == BYTE_NUL)
            zero_seen = 1'b1;

        hit   = 1'b0;
        start = '0;
        if (col_ok && !zero_seen && eff_len > 0 && col >= eff_len) begin
            start = col - COL_OUT_W'(eff_len);
            if (start >= next_start) begin
                hit = 1'b1;
                for (int i = 0; i < eff_len; i++)
                    if (pat[8*i +: 8] != recent[eff_len-1-i])
                        hit = 1'b0;
            end
        end

        r.match_found     = hit;
        r.match_line      = line_no;
        r.match_column    = hit ? start + 1'b1 : '0;
        r.printable_count = printable_total;
        r.other_count     = other_total;

        // Matches never overlap within a line
        if (hit)
            next_start = col;
        if (b == BYTE_NL) begin
            if (line_no != LINE_MAX)
                line_no++;
            col        = '0;
            next_start = '0;
            zero_seen  = 1'b0;
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;

        got.match_found     = i_m_tuser[0];
        got.match_line      = i_m_tdata[31:0];
        got.match_column    = i_m_tdata[47:32];
        got.printable_count = i_m_tdata[79:48];
        got.other_count     = i_m_tdata[111:80];
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, line", got.match_line, '0);
        end else begin
            want = pending_results.pop_front();
            if (got.match_found !== want.match_found)
                report_mismatch("match_found", 32'(got.match_found),
                                32'(want.match_found));
            if (got.match_line !== want.match_line)
                report_mismatch("match_line", got.match_line, want.match_line);
            if (got.match_column !== want.match_column)
                report_mismatch("match_column", 32'(got.match_column),
                                32'(want.match_column));
            if (got.printable_count !== want.printable_count)
                report_mismatch("printable_count", got.printable_count,
                                want.printable_count);
            if (got.other_count !== want.other_count)
                report_mismatch("other_count", got.other_count, want.other_count);
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge i_clk) begin
        t_result next_result;

        if (!i_rst_n) begin
            clear_matcher();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PAT_LO:  pat_lo = i_cfg_data;
                    REG_PAT_HI:  pat_hi = i_cfg_data;
                    REG_PAT_LEN: pat_len = i_cfg_data[PAT_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_line_result(i_s_tdata, next_result);
                pending_results.push_back(next_result);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ----- tb/tb_streaming_substring_line_matcher_top.sv -----
// Testbench top for the streaming line matcher: clock, reset, text and config stimulus,
// receiver back-pressure and the final verdict.
// Depends on slm_pkg, the matcher RTL and line_match_checker.
`timescale 1ns / 1ps

module tb_streaming_substring_line_matcher_top;
    import slm_pkg::*;

    localparam int                   CYCLE_LIMIT   = 60000;
    localparam int                   LONG_HOLD     = 300;
    localparam int                   PHASE_ITEMS   = 210;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
    localparam logic [7:0]           CHAR_A        = 8'h61;
    localparam logic [7:0]           CHAR_B        = 8'h62;
    localparam logic [7:0]           CHAR_C        = 8'h63;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;

    // Idling percentages and the long receiver hold request
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_trigger  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    // Pattern currently loaded, and how many bytes of it a copy in the text uses
    logic [127:0] pat;
    int           copy_len;

    always #5 clk = ~clk;

    streaming_substring_line_matcher_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    line_match_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Receiver: random stalls, or a long hold when requested
    always @(negedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[streaming_substring_line_matcher_top] ERROR");
            $finish;
        end
    end

    // All stimulus tasks start and end at a falling edge
    task automatic send_text_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_pattern(input logic [127:0] p, input logic [CFG_DATA_W-1:0] len_word);
        int eff;

        drain_results();
        write_reg(REG_PAT_LO, p[63:0]);
        write_reg(REG_PAT_HI, p[127:64]);
        write_reg(REG_PAT_LEN, len_word);
        pat      = p;
        eff      = (len_word[PAT_LEN_W-1:0] > PAT_BYTES) ? PAT_BYTES
                                                         : int'(len_word[PAT_LEN_W-1:0]);
        copy_len = (eff == 0) ? 4 : eff;
    endtask

    // Mostly a small alphabet so that text built from it matches often
    function automatic logic [127:0] random_pattern();
        logic [127:0] p;
        int           pick;

        for (int i = 0; i < PAT_BYTES; i++) begin
            pick = $urandom_range(9);
            if (pick < 3)
                p[8*i +: 8] = CHAR_A;
            else if (pick < 6)
                p[8*i +: 8] = CHAR_B;
            else if (pick < 8)
                p[8*i +: 8] = CHAR_C;
            else
                p[8*i +: 8] = 8'($urandom_range(255));
        end
        return p;
    endfunction

    // Pattern copies (some broken), pattern-alphabet filler, newlines, zeros and noise
    task automatic run_text_phase(input int n_items, input int hold_at, input int pause_at);
        int         sent;
        int         cut;
        int         pick;
        int         idx;
        bit         held;
        bit         paused;
        logic [7:0] b;

        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!held && hold_at >= 0 && sent >= hold_at) begin
                hold_trigger++;
                held = 1'b1;
            end
            if (!paused && pause_at >= 0 && sent >= pause_at) begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                cut = ($urandom_range(3) == 0) ? $urandom_range(copy_len) : copy_len;
                for (int k = 0; k < cut; k++) begin
                    b = pat[8*k +: 8];
                    if ($urandom_range(19) == 0)
                        b = 8'($urandom_range(255));
                    send_text_byte(b);
                    sent++;
                end
            end else begin
                if (pick < 75) begin
                    idx = $urandom_range(PAT_BYTES - 1);
                    b   = pat[8*idx +: 8];
                end else if (pick < 85) begin
                    b = BYTE_NL;
                end else if (pick < 89) begin
                    b = BYTE_NUL;
                end else begin
                    b = 8'($urandom_range(255));
                end
                send_text_byte(b);
                sent++;
            end
        end
    endtask

    // Opening text for pattern "aa": non-overlap, zero byte, new line, byte classes
    logic [7:0] opening_text [19] = '{
        CHAR_A, CHAR_A, CHAR_A, CHAR_A, BYTE_NUL, CHAR_A, CHAR_A, BYTE_NL,
        CHAR_A, CHAR_A, BYTE_NL,
        8'hFF, BYTE_DEL, BYTE_SPACE, 8'h1F, 8'h80, 8'h7E, 8'h21, BYTE_NL
    };

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles less than the receiver
        send_idle_pct = 26;
        recv_idle_pct = 46;

        // Reset pattern is a single zero byte, which never matches
        send_text_byte(8'h78);
        send_text_byte(BYTE_NUL);

        load_pattern({64'h0, 48'h0, CHAR_A, CHAR_A}, 64'd2);
        foreach (opening_text[i])
            send_text_byte(opening_text[i]);

        load_pattern(random_pattern(), 64'd16);
        run_text_phase(PHASE_ITEMS, -1, -1);

        load_pattern(random_pattern(), 64'd1);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        run_text_phase(PHASE_ITEMS, -1, -1);

        // Zero length: nothing matches
        load_pattern('0, 64'd0);
        run_text_phase(PHASE_ITEMS, -1, -1);

        // Receiver idles less than the sender
        send_idle_pct = 46;
        recv_idle_pct = 26;

        // All-ones data, length field 31 reads as the maximum
        load_pattern('1, '1);
        run_text_phase(PHASE_ITEMS, -1, -1);

        // Garbage above the length field; long receiver hold mid-phase
        load_pattern(random_pattern(),
                     {$urandom, 27'($urandom), 5'($urandom_range(1, 16))});
        run_text_phase(PHASE_ITEMS, 50, -1);

        // Sender pauses until everything has come back
        load_pattern(random_pattern(), 64'($urandom_range(1, 16)));
        run_text_phase(PHASE_ITEMS, -1, PHASE_ITEMS / 2);

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;

        load_pattern(random_pattern(), 64'($urandom_range(2, 5)));
        run_text_phase(PHASE_ITEMS, -1, -1);

        load_pattern(random_pattern(), 64'($urandom_range(1, 16)));
        run_text_phase(PHASE_ITEMS, 20, -1);

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[streaming_substring_line_matcher_top] OK");
        else
            $display("[streaming_substring_line_matcher_top] ERROR");
        $finish;
    end

endmodule
